FILE: rtl/life_grid_generation_engine_defines.svh
// ----------------------------------------------------------------------------
// Life grid generation engine: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH

// check c in the same cycle as a
`define LGE_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("lge assertion failed");

// check c in the cycle after a
`define LGE_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("lge assertion failed");

`endif

FILE: rtl/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Grid geometry, operation codes, control types and the B3/S23 row rule.
// ----------------------------------------------------------------------------
package lge_pkg;

	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 32;
	localparam int RW = $clog2(GRID_HEIGHT);
	localparam int CW = $clog2(GRID_HEIGHT + 2);
	localparam int XW = (CW > 5) ? CW : 5;

	typedef logic [GRID_WIDTH-1:0] row_t;

	typedef enum logic [1:0] {
		OP_TOGGLE = 2'd0,
		OP_STEP   = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic capture;
		logic rd_row;
		logic rd_step;
		logic win_load;
		logic row_wr;
		logic res_load;
	} lge_cmd_t;

	typedef struct packed {
		logic last_row;
		logic busy_step;
	} lge_sts_t;

	function automatic row_t next_row(row_t above, row_t here, row_t below);
		logic [GRID_WIDTH+1:0] a;
		logic [GRID_WIDTH+1:0] h;
		logic [GRID_WIDTH+1:0] b;
		logic [3:0]            n;
		row_t                  res;
		a = {1'b0, above, 1'b0};
		h = {1'b0, here, 1'b0};
		b = {1'b0, below, 1'b0};
		res = '0;
		for (int j = 0; j < GRID_WIDTH; j++) begin
			n = 4'(a[j]) + 4'(a[j+1]) + 4'(a[j+2]) + 4'(h[j]) + 4'(h[j+2])
				+ 4'(b[j]) + 4'(b[j+1]) + 4'(b[j+2]);
			res[j] = (n == 4'd3) || (h[j+1] && (n == 4'd2));
		end
		return res;
	endfunction

endpackage

FILE: rtl/lge_req_if.sv
// ----------------------------------------------------------------------------
// Life grid request channel
// Valid/ready channel carrying one operation with its cell address.
// ----------------------------------------------------------------------------
interface lge_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [4:0] row_index;
	logic [4:0] column_index;

	modport source (output valid, operation, row_index, column_index, input ready);
	modport sink (input valid, operation, row_index, column_index, output ready);
endinterface

FILE: rtl/lge_rsp_if.sv
// ----------------------------------------------------------------------------
// Life grid response channel
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface lge_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] row_bits;
	logic        cell_alive;
	logic        op_done;

	modport source (output valid, row_bits, cell_alive, op_done, input ready);
	modport sink (input valid, row_bits, cell_alive, op_done, output ready);
endinterface

FILE: rtl/lge_ctrl.sv
// ----------------------------------------------------------------------------
// Life grid controller
// Sequences toggle, read and generation sweeps and owns the result valid flag.
// ----------------------------------------------------------------------------
module lge_ctrl import lge_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_operation,
	output logic       req_ready,
	input  logic       rsp_ready,
	output logic       rsp_valid,
	output lge_cmd_t   cmd,
	input  lge_sts_t   sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PRIME = 6'b000010,
		S_LOAD  = 6'b000100,
		S_ROW   = 6'b001000,
		S_RD    = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = (op_t'(req_operation) == OP_STEP) ? S_PRIME : S_RD;
				end
			end
			S_PRIME: begin
				cmd.rd_step = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.rd_step  = 1'b1;
				cmd.win_load = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.rd_step = 1'b1;
				cmd.row_wr  = 1'b1;
				if (sts.last_row) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_row = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lge_dp.sv
// ----------------------------------------------------------------------------
// Life grid datapath
// Row memory with per-row valid bits, three-row window, rule logic and
// the result register.
// ----------------------------------------------------------------------------
module lge_dp import lge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lge_cmd_t    cmd,
	output lge_sts_t    sts,
	input  logic [1:0]  operation,
	input  logic [4:0]  row_index,
	input  logic [4:0]  column_index,
	output logic [31:0] row_bits,
	output logic        cell_alive,
	output logic        op_done
);

	op_t                  op_q;
	logic [4:0]           row_q;
	logic [4:0]           col_q;
	logic [CW-1:0]        rd_ptr_q;
	logic [CW-1:0]        wr_ptr_q;
	row_t                 above_q;
	row_t                 here_q;
	row_t                 mem [GRID_HEIGHT];
	logic [GRID_HEIGHT-1:0] vld_q;
	row_t                 rd_data_q;
	logic                 rd_inb_q;
	logic                 rd_vld_q;
	logic [31:0]          row_bits_q;
	logic                 cell_alive_q;
	logic                 op_done_q;

	logic [XW-1:0]        rd_addr;
	logic                 rd_inb;
	logic [RW-1:0]        rd_idx;
	row_t                 rd_row;
	logic                 addr_ok;
	row_t                 toggled;
	row_t                 new_row;
	row_t                 picked;
	logic [63:0]          wide;
	row_t                 nxt;
	logic                 wr_en;
	logic [RW-1:0]        wr_idx;
	row_t                 wr_data;

	assign rd_addr = cmd.rd_step ? XW'(rd_ptr_q) : XW'(row_q);
	assign rd_inb  = int'(rd_addr) < GRID_HEIGHT;
	assign rd_idx  = rd_addr[RW-1:0];
	assign rd_row  = (rd_inb_q && rd_vld_q) ? rd_data_q : '0;

	assign addr_ok = (int'(row_q) < GRID_HEIGHT) && (int'(col_q) < GRID_WIDTH);
	assign toggled = rd_row ^ (row_t'(1) << col_q);
	assign new_row = ((op_q == OP_TOGGLE) && addr_ok) ? toggled : rd_row;
	assign picked  = new_row >> col_q;
	assign wide    = 64'(new_row);
	assign nxt     = next_row(above_q, here_q, rd_row);

	assign wr_en   = cmd.row_wr || (cmd.res_load && (op_q == OP_TOGGLE) && addr_ok);
	assign wr_idx  = cmd.row_wr ? wr_ptr_q[RW-1:0] : RW'(row_q);
	assign wr_data = cmd.row_wr ? nxt : toggled;

	assign sts.last_row  = (int'(wr_ptr_q) == GRID_HEIGHT - 1);
	assign sts.busy_step = (op_q == OP_STEP);

	assign row_bits   = row_bits_q;
	assign cell_alive = cell_alive_q;
	assign op_done    = op_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (cmd.capture) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (cmd.rd_step) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
				if (cmd.row_wr) begin
					wr_ptr_q <= wr_ptr_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (cmd.rd_step || cmd.rd_row) begin
			rd_inb_q <= rd_inb;
			if (rd_inb) begin
				rd_data_q <= mem[rd_idx];
				rd_vld_q  <= vld_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			row_q <= row_index;
			col_q <= column_index;
		end
		if (cmd.win_load) begin
			above_q <= '0;
			here_q  <= rd_row;
		end else if (cmd.row_wr) begin
			above_q <= here_q;
			here_q  <= rd_row;
		end
		if (cmd.res_load) begin
			row_bits_q   <= (op_q == OP_READ) ? wide[31:0] : 32'd0;
			cell_alive_q <= (op_q != OP_NONE) && addr_ok && picked[0];
			op_done_q    <= (op_q != OP_NONE);
		end
	end

endmodule

FILE: rtl/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded Life grid (B3/S23) with toggle, generation step and row read.
// ----------------------------------------------------------------------------
// One item at a time: a request is taken while the engine is idle and gives
// one response. Toggle and read pass through the read and finish states to
// the response register; a generation step first passes through the prime
// and load states and sweeps the row memory, reading one row and writing one
// new row per cycle through a three-row window. The next request is taken
// once the response is registered, even while that response waits to be taken.
// Cells start dead after reset through per-row valid bits, with no clearing
// pass.
// ----------------------------------------------------------------------------
`include "life_grid_generation_engine_defines.svh"

module life_grid_generation_engine import lge_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	lge_req_if.sink req,
	lge_rsp_if.source rsp
);

	lge_cmd_t cmd;
	lge_sts_t sts;

	lge_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.cmd           (cmd),
		.sts           (sts)
	);

	lge_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (req.operation),
		.row_index    (req.row_index),
		.column_index (req.column_index),
		.row_bits     (rsp.row_bits),
		.cell_alive   (rsp.cell_alive),
		.op_done      (rsp.op_done)
	);

	`LGE_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, req.valid && req.ready, !req.ready)
	`LGE_ASSERT_SAME(a_none_is_blank, clk, arst_n, rsp.valid && !rsp.op_done, (rsp.row_bits == 32'd0) && !rsp.cell_alive)
	`LGE_ASSERT_SAME(a_sweep_only_on_step, clk, arst_n, cmd.row_wr, sts.busy_step)

endmodule

FILE: tb/life_grid_generation_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Requests drawn from corner toggles, still lifes, oscillators and random
// cell patterns go through the request channel. A local B3/S23 grid model
// predicts every response, and the responses are checked in order, with
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_test;
	import lge_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 3 * (GRID_HEIGHT + 5);

	typedef struct packed {
		op_t        op;
		logic [4:0] row;
		logic [4:0] col;
	} grid_request_t;

	typedef struct packed {
		logic [31:0] row_bits;
		logic        cell_alive;
		logic        op_done;
	} grid_response_t;

	logic clk;
	logic arst_n;

	lge_req_if req ();
	lge_rsp_if rsp ();

	life_grid_generation_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	row_t           board [GRID_HEIGHT];
	grid_request_t  grid_requests [$];
	grid_response_t expected_responses [$];

	int send_idle_pct;
	int rsp_stall_pct;
	int rsp_hold_left;
	int issued_count;
	int completed_count;
	int mismatch_count;
	int cycle_count;
	bit req_transfer_seen;

	function automatic row_t life_row(row_t up, row_t mid, row_t dn);
		row_t nxt;
		int   n;
		nxt = '0;
		for (int j = 0; j < GRID_WIDTH; j++) begin
			n = 0;
			for (int dj = -1; dj <= 1; dj++) begin
				if (j + dj >= 0 && j + dj < GRID_WIDTH) begin
					n += int'(up[j + dj]) + int'(dn[j + dj]);
					if (dj != 0)
						n += int'(mid[j + dj]);
				end
			end
			nxt[j] = (n == 3) || (mid[j] && n == 2);
		end
		return nxt;
	endfunction

	function automatic void advance_generation();
		row_t prior [GRID_HEIGHT];
		row_t up;
		row_t dn;
		prior = board;
		for (int i = 0; i < GRID_HEIGHT; i++) begin
			up = (i > 0) ? prior[i - 1] : '0;
			dn = (i + 1 < GRID_HEIGHT) ? prior[i + 1] : '0;
			board[i] = life_row(up, prior[i], dn);
		end
	endfunction

	function automatic grid_response_t apply_request(grid_request_t item);
		grid_response_t res;
		bit             row_ok;
		bit             cell_ok;
		res = '0;
		row_ok = int'(item.row) < GRID_HEIGHT;
		cell_ok = row_ok && int'(item.col) < GRID_WIDTH;
		case (item.op)
			OP_TOGGLE: begin
				if (cell_ok)
					board[item.row][item.col] = ~board[item.row][item.col];
			end
			OP_STEP: begin
				advance_generation();
			end
			OP_READ: begin
				if (row_ok)
					res.row_bits = 32'(board[item.row]);
			end
			default: ;
		endcase
		res.op_done = (item.op != OP_NONE);
		if (res.op_done && cell_ok)
			res.cell_alive = board[item.row][item.col];
		return res;
	endfunction

	task automatic push_request(input op_t op, input int row, input int col);
		grid_request_t item;
		item.op = op;
		item.row = 5'(row);
		item.col = 5'(col);
		grid_requests.push_back(item);
		issued_count++;
	endtask

	task automatic queue_random_request(input int base_row, input int base_col);
		int  pick;
		op_t op;
		int  row;
		int  col;
		pick = $urandom_range(99, 0);
		if (pick < 48)
			op = OP_TOGGLE;
		else if (pick < 62)
			op = OP_STEP;
		else if (pick < 96)
			op = OP_READ;
		else
			op = OP_NONE;
		if ($urandom_range(9, 0) < 7) begin
			row = (base_row + $urandom_range(7, 0)) % 32;
			col = (base_col + $urandom_range(7, 0)) % 32;
		end else begin
			row = $urandom_range(31, 0);
			col = $urandom_range(31, 0);
		end
		push_request(op, row, col);
	endtask

	task automatic run_phase(input int sender_idle, input int receiver_stall, input int count,
			input int hold_cycles);
		int base_row;
		int base_col;
		send_idle_pct = sender_idle;
		rsp_stall_pct = receiver_stall;
		rsp_hold_left = hold_cycles;
		base_row = 0;
		base_col = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 0) begin
				base_row = $urandom_range(31, 0);
				base_col = $urandom_range(31, 0);
			end
			queue_random_request(base_row, base_col);
		end
		while (completed_count != issued_count)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// drive one request; hold it until its transfer
	always @(negedge clk) begin
		grid_request_t item;
		if (arst_n && (!req.valid || req_transfer_seen)) begin
			req_transfer_seen = 1'b0;
			if (grid_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				item = grid_requests.pop_front();
				req.valid <= 1'b1;
				req.operation <= item.op;
				req.row_index <= item.row;
				req.column_index <= item.col;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		grid_request_t  item;
		grid_response_t got;
		grid_response_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got.row_bits = rsp.row_bits;
				got.cell_alive = rsp.cell_alive;
				got.op_done = rsp.op_done;
				completed_count++;
				if (expected_responses.size() == 0) begin
					mismatch_count++;
					$display("%0t: expected no response, ", $time,
						"got row_bits=%h cell_alive=%b op_done=%b",
						got.row_bits, got.cell_alive, got.op_done);
				end else begin
					want = expected_responses.pop_front();
					if (got !== want) begin
						mismatch_count++;
						$display("%0t: expected row_bits=%h cell_alive=%b op_done=%b, ",
							$time, want.row_bits, want.cell_alive, want.op_done,
							"got row_bits=%h cell_alive=%b op_done=%b",
							got.row_bits, got.cell_alive, got.op_done);
					end
				end
			end
			if (req.valid && req.ready) begin
				item.op = op_t'(req.operation);
				item.row = req.row_index;
				item.col = req.column_index;
				expected_responses.push_back(apply_request(item));
				req_transfer_seen = 1'b1;
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.operation = OP_TOGGLE;
		req.row_index = '0;
		req.column_index = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		rsp_hold_left = 0;
		for (int i = 0; i < GRID_HEIGHT; i++)
			board[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// dead grid, no-op codes, corners
		push_request(OP_READ, 0, 0);
		push_request(OP_READ, 31, 31);
		push_request(OP_NONE, 31, 31);
		push_request(OP_NONE, 0, 0);
		push_request(OP_TOGGLE, 0, 0);
		push_request(OP_TOGGLE, 0, 31);
		push_request(OP_TOGGLE, 31, 0);
		push_request(OP_TOGGLE, 31, 31);
		push_request(OP_READ, 0, 31);
		push_request(OP_READ, 31, 0);
		push_request(OP_STEP, 0, 0);
		push_request(OP_READ, 0, 0);
		push_request(OP_TOGGLE, 5, 5);
		push_request(OP_TOGGLE, 5, 5);
		// blinker
		push_request(OP_TOGGLE, 10, 9);
		push_request(OP_TOGGLE, 10, 10);
		push_request(OP_TOGGLE, 10, 11);
		push_request(OP_STEP, 9, 10);
		push_request(OP_READ, 9, 10);
		push_request(OP_READ, 11, 10);
		push_request(OP_STEP, 10, 11);
		push_request(OP_READ, 10, 0);
		// block in the corner, a still life that survives a step
		push_request(OP_TOGGLE, 0, 0);
		push_request(OP_TOGGLE, 0, 1);
		push_request(OP_TOGGLE, 1, 0);
		push_request(OP_TOGGLE, 1, 1);
		push_request(OP_STEP, 1, 1);
		push_request(OP_READ, 0, 1);
		while (completed_count != issued_count)
			@(posedge clk);

		run_phase(0, 0, 300, 400);
		run_phase(47, 0, 300, 0);
		run_phase(0, 47, 300, 0);
		run_phase(30, 30, 300, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_responses.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d responses never arrived", $time, expected_responses.size());
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
